// ===== sv/ccl_pkg.sv =====
`timescale 1ns / 1ps
package ccl_pkg;

    localparam int WAYS       = 4;
    localparam int SETS       = 1024;
    localparam int LINE_BYTES = 64;
    localparam int AGE_BITS   = 8;

    localparam int WAY_BITS = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int OFF_BITS = $clog2(LINE_BYTES);
    localparam int SET_BITS = $clog2(SETS);
    localparam int TAG_BITS = 32 - OFF_BITS - SET_BITS;

    localparam int CTR_SHIFT_IN  = 16;
    localparam int CTR_SHIFT_OUT = 14;

    localparam logic [31:0] BASE_RESET = 32'd2097152;
    localparam logic [AGE_BITS-1:0] AGE_TOP = '1;

    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_STORE = 2'd1;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] data_address;
    } ccl_in_t;

    typedef struct packed {
        logic [31:0] counter_address;
        logic        hit;
        logic        fill_request;
        logic        tree_read_request;
        logic        integrity_write_request;
        logic        writeback;
        logic [31:0] victim_address;
        logic [1:0]  way_used;
    } ccl_out_t;

    // controller to datapath
    typedef struct packed {
        logic clear;
        logic capture;
        logic update;
    } ccl_cmd_t;

endpackage

// ===== sv/ccl_ctrl.sv =====
`timescale 1ns / 1ps
module ccl_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               clear_last,
    output logic               busy,
    output ccl_pkg::ccl_cmd_t  cmd
);
    import ccl_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_LOOK  = 3'b100
    } state_t;

    state_t state_reg, state_next;

    // clear rows after reset -> idle -> lookup (set read done, row update) -> idle
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: if (clear_last) state_next = ST_IDLE;
            ST_IDLE:  if (start) state_next = ST_LOOK;
            ST_LOOK:  state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_CLEAR;
        else
            state_reg <= state_next;
    end

    assign busy        = (state_reg != ST_IDLE);
    assign cmd.clear   = (state_reg == ST_CLEAR);
    assign cmd.capture = (state_reg == ST_IDLE) && start;
    assign cmd.update  = (state_reg == ST_LOOK);
endmodule

// ===== sv/ccl_datapath.sv =====
`timescale 1ns / 1ps
module ccl_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  ccl_pkg::ccl_cmd_t  cmd,
    input  ccl_pkg::ccl_in_t   item,
    input  logic               cfg_we,
    input  logic [31:0]        cfg_data,
    output ccl_pkg::ccl_out_t  result,
    output logic               done,
    output logic               clear_last
);
    import ccl_pkg::*;

    logic [31:0] base_reg;
    // per set: valid bits, dirty bits, ages
    logic [2*WAYS+WAYS*AGE_BITS-1:0] meta_mem [SETS];
    logic [WAYS*TAG_BITS-1:0] tag_row [SETS];
    logic [SET_BITS-1:0] clr_idx_reg;

    logic [31:0] ca;
    logic [31:0] ca_reg;
    logic [1:0]  op_reg;
    logic [WAYS*TAG_BITS-1:0] tags_rd_reg;
    logic [WAYS-1:0] valid_rd_reg;
    logic [WAYS-1:0] dirty_rd_reg;
    logic [WAYS*AGE_BITS-1:0] ages_rd_reg;
    logic [SET_BITS-1:0] set_reg;
    logic [TAG_BITS-1:0] tag_reg;

    ccl_out_t result_reg, result_next;
    logic     done_reg;

    // counter address mapping
    assign ca = ({2'b00, item.data_address[31:CTR_SHIFT_IN], {CTR_SHIFT_OUT{1'b0}}}
                 | {30'd0, item.data_address[1:0]}) + base_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            base_reg <= BASE_RESET;
        else if (cfg_we)
            base_reg <= cfg_data;
    end

    // row clearing pass after reset, one set per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_idx_reg <= '0;
        else if (cmd.clear)
            clr_idx_reg <= clr_idx_reg + 1'b1;
    end

    assign clear_last = (clr_idx_reg == '1);

    // stage 1: register item and read the set row
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            ca_reg      <= ca;
            op_reg      <= item.command;
            set_reg     <= ca[OFF_BITS +: SET_BITS];
            tag_reg     <= ca[31 -: TAG_BITS];
            tags_rd_reg <= tag_row[ca[OFF_BITS +: SET_BITS]];
            {valid_rd_reg, dirty_rd_reg, ages_rd_reg} <= meta_mem[ca[OFF_BITS +: SET_BITS]];
        end
    end

    // stage 2: lookup, victim choice, new ages
    logic [WAYS-1:0] v_row, d_row, hit_vec;
    logic [WAYS-1:0] new_v_row, new_d_row;
    logic [WAYS*AGE_BITS-1:0] new_ages;
    logic [WAY_BITS-1:0] way;
    logic hit, found, active, store_op, wb;
    logic [AGE_BITS-1:0] hage, best, a;
    logic [AGE_BITS:0] s;
    logic [1:0] by;

    always_comb
    begin
        v_row    = valid_rd_reg;
        d_row    = dirty_rd_reg;
        active   = (op_reg == CMD_LOAD) || (op_reg == CMD_STORE);
        store_op = (op_reg == CMD_STORE);
        hit = 1'b0; found = 1'b0; way = '0; best = '0; wb = 1'b0; by = 2'd0;
        for (int w = 0; w < WAYS; w++)
            hit_vec[w] = v_row[w] && (tags_rd_reg[w*TAG_BITS +: TAG_BITS] == tag_reg);
        for (int w = WAYS-1; w >= 0; w--)
            if (hit_vec[w])
            begin
                hit = 1'b1;
                way = WAY_BITS'(w);
            end
        if (!hit)
        begin
            for (int w = WAYS-1; w >= 0; w--)
                if (!v_row[w])
                begin
                    found = 1'b1;
                    way   = WAY_BITS'(w);
                end
            if (found)
                by = 2'd2;
            else
            begin
                by = 2'd1;
                for (int w = 0; w < WAYS; w++)
                    if (ages_rd_reg[w*AGE_BITS +: AGE_BITS] >= best)
                    begin
                        best = ages_rd_reg[w*AGE_BITS +: AGE_BITS];
                        way  = WAY_BITS'(w);
                    end
                wb = d_row[way];
            end
        end
        hage = ages_rd_reg[way*AGE_BITS +: AGE_BITS];
        for (int w = 0; w < WAYS; w++)
        begin
            a = ages_rd_reg[w*AGE_BITS +: AGE_BITS];
            if (hit)
                s = (a < hage) ? {1'b0, a} + 1'b1 : {1'b0, a};
            else
                s = {1'b0, a} + {{(AGE_BITS-1){1'b0}}, by};
            new_ages[w*AGE_BITS +: AGE_BITS] = (s > {1'b0, AGE_TOP}) ? AGE_TOP
                                               : s[AGE_BITS-1:0];
        end
        new_ages[way*AGE_BITS +: AGE_BITS] = '0;
        new_v_row = v_row;
        new_v_row[way] = 1'b1;
        new_d_row = d_row;
        if (hit)
            new_d_row[way] = d_row[way] | store_op;
        else
            new_d_row[way] = store_op;

        result_next = '0;
        result_next.counter_address = ca_reg;
        if (active)
        begin
            result_next.hit                     = hit;
            result_next.fill_request            = !hit;
            result_next.tree_read_request       = !hit && !store_op;
            result_next.integrity_write_request = store_op;
            result_next.writeback               = wb;
            if (wb)
                result_next.victim_address =
                    {tags_rd_reg[way*TAG_BITS +: TAG_BITS], set_reg, {OFF_BITS{1'b0}}};
            result_next.way_used = 2'(way);
        end
    end

    // row write-back: valid, dirty and ages; zeroed by the clearing pass
    always_ff @(posedge clk)
    begin
        if (cmd.clear)
            meta_mem[clr_idx_reg] <= '0;
        else if (cmd.update && active)
            meta_mem[set_reg] <= {new_v_row, new_d_row, new_ages};
    end

    // tags stored per row, one way per entry group
    always_ff @(posedge clk)
    begin
        if (cmd.update && active && !hit)
            tag_row[set_reg][way*TAG_BITS +: TAG_BITS] <= tag_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= cmd.update;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.update)
            result_reg <= result_next;
    end

    assign result = result_reg;
    assign done   = done_reg;
endmodule

// ===== sv/counter_cache_lookup_lru.sv =====
`timescale 1ns / 1ps
// Channel   Ports                      Transfer
// config    base_we, base_data         base_we high at clock edge
// command   start, busy, item          start high and busy low
// result    done, result               done high for one cycle
// Items are taken one at a time: capture reads the set row, then the lookup
// does the compare, victim choice and row write-back; the result appears the
// cycle after. After reset busy stays high while the valid, dirty and age
// rows of every set are cleared; the base returns to its reset value.
// The receiver cannot stall, so results never wait.
module counter_cache_lookup_lru (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  ccl_pkg::ccl_in_t   item,
    input  logic               base_we,
    input  logic [31:0]        base_data,
    output logic               done,
    output ccl_pkg::ccl_out_t  result
);
    import ccl_pkg::*;

    ccl_cmd_t cmd;
    logic     clear_last;

    ccl_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .clear_last (clear_last),
        .busy       (busy),
        .cmd        (cmd)
    );

    ccl_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .item       (item),
        .cfg_we     (base_we),
        .cfg_data   (base_data),
        .result     (result),
        .done       (done),
        .clear_last (clear_last)
    );
endmodule

// ===== tb/tb_counter_cache_lookup_lru.sv =====
`timescale 1ns / 1ps
module tb_counter_cache_lookup_lru;
    import ccl_pkg::*;

    localparam logic [1:0] CMD_EMPTY = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    ccl_in_t item;
    logic base_we;
    logic [31:0] base_data;
    logic done;
    ccl_out_t result;

    counter_cache_lookup_lru u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .item(item),
        .base_we(base_we), .base_data(base_data), .done(done), .result(result)
    );

    // shadow cache state
    logic [TAG_BITS-1:0] sh_tag [WAYS*SETS];
    logic sh_valid [WAYS*SETS];
    logic sh_dirty [WAYS*SETS];
    logic [AGE_BITS-1:0] sh_age [WAYS*SETS];
    logic [31:0] sh_base;

    ccl_in_t pending_items[$];
    ccl_out_t expected_lookups[$];
    int errors = 0;
    int send_idle_pct = 0;
    bit in_xfer = 0;

    function automatic logic [AGE_BITS-1:0] age_add(logic [AGE_BITS-1:0] a, int by);
        int s;
        s = int'(a) + by;
        return (s > int'(AGE_TOP)) ? AGE_TOP : s[AGE_BITS-1:0];
    endfunction

    // predicts one lookup and updates the shadow cache
    function automatic ccl_out_t predict_lookup(ccl_in_t it);
        ccl_out_t r;
        logic [31:0] ca;
        logic [SET_BITS-1:0] set_idx;
        logic [TAG_BITS-1:0] tag;
        int b, way, by;
        bit found, is_st;
        logic [AGE_BITS-1:0] ha, best;
        r = '0;
        ca = (((it.data_address >> CTR_SHIFT_IN) << CTR_SHIFT_OUT)
              | (it.data_address & 32'd3)) + sh_base;
        r.counter_address = ca;
        if (it.command != CMD_LOAD && it.command != CMD_STORE)
            return r;
        set_idx = ca[OFF_BITS +: SET_BITS];
        tag = ca[31 -: TAG_BITS];
        b = int'(set_idx) * WAYS;
        is_st = (it.command == CMD_STORE);
        found = 0;
        way = 0;
        for (int w = 0; w < WAYS; w++)
            if (!found && sh_valid[b+w] && sh_tag[b+w] == tag)
            begin
                found = 1;
                way = w;
            end
        if (found)
        begin
            ha = sh_age[b+way];
            for (int w = 0; w < WAYS; w++)
                if (sh_age[b+w] < ha)
                    sh_age[b+w] = age_add(sh_age[b+w], 1);
            sh_age[b+way] = '0;
            if (is_st)
                sh_dirty[b+way] = 1;
        end
        else
        begin
            bit inv;
            inv = 0;
            for (int w = 0; w < WAYS; w++)
                if (!inv && !sh_valid[b+w])
                begin
                    inv = 1;
                    way = w;
                end
            if (inv)
                by = 2;
            else
            begin
                by = 1;
                best = '0;
                for (int w = 0; w < WAYS; w++)
                    if (sh_age[b+w] >= best)
                    begin
                        best = sh_age[b+w];
                        way = w;
                    end
                if (sh_dirty[b+way])
                begin
                    r.writeback = 1;
                    r.victim_address = {sh_tag[b+way], set_idx, {OFF_BITS{1'b0}}};
                end
            end
            sh_tag[b+way] = tag;
            sh_valid[b+way] = 1;
            sh_dirty[b+way] = is_st;
            for (int w = 0; w < WAYS; w++)
                sh_age[b+w] = age_add(sh_age[b+w], by);
            sh_age[b+way] = '0;
        end
        r.hit = found;
        r.fill_request = !found;
        r.tree_read_request = !found && !is_st;
        r.integrity_write_request = is_st;
        r.way_used = way[1:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    // driver: presents items from the queue at falling edges,
    // the next one only once the last transfer has been seen
    always @(negedge clk)
    begin
        if (!rst_n)
            start <= 0;
        else if (!start || in_xfer)
        begin
            if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                item <= pending_items.pop_front();
                start <= 1;
            end
            else
                start <= 0;
        end
    end

    // predictor on accepted transfers, checker on results
    always @(posedge clk)
    begin
        in_xfer = rst_n && start && !busy;
        if (in_xfer)
            expected_lookups.push_back(predict_lookup(item));
        if (rst_n && done)
        begin
            if (expected_lookups.size() == 0)
            begin
                $display("unexpected result at %0t", $realtime);
                errors++;
            end
            else
            begin
                ccl_out_t e;
                e = expected_lookups.pop_front();
                if (result.counter_address !== e.counter_address)
                    report_mismatch("counter_address", result.counter_address, e.counter_address);
                if (result.hit !== e.hit)
                    report_mismatch("hit", 32'(result.hit), 32'(e.hit));
                if (result.fill_request !== e.fill_request)
                    report_mismatch("fill_request", 32'(result.fill_request),
                                    32'(e.fill_request));
                if (result.tree_read_request !== e.tree_read_request)
                    report_mismatch("tree_read_request", 32'(result.tree_read_request),
                                    32'(e.tree_read_request));
                if (result.integrity_write_request !== e.integrity_write_request)
                    report_mismatch("integrity_write_request",
                                    32'(result.integrity_write_request),
                                    32'(e.integrity_write_request));
                if (result.writeback !== e.writeback)
                    report_mismatch("writeback", 32'(result.writeback), 32'(e.writeback));
                if (result.victim_address !== e.victim_address)
                    report_mismatch("victim_address", result.victim_address, e.victim_address);
                if (result.way_used !== e.way_used)
                    report_mismatch("way_used", 32'(result.way_used), 32'(e.way_used));
            end
        end
    end

    // data address that lands on one of a few sets, with random tag bits
    function automatic logic [31:0] hot_address();
        logic [31:0] a;
        a = $urandom;
        a[15:2] = 14'($urandom);
        a[25:16] = {2'($urandom_range(3)), 7'h00, 1'($urandom_range(1))};
        a[31:26] = 6'($urandom_range(5));
        return a;
    endfunction

    task automatic wait_drained();
        while (pending_items.size() > 0 || start || expected_lookups.size() > 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_base(logic [31:0] v);
        base_we <= 1;
        base_data <= v;
        @(negedge clk);
        base_we <= 0;
        sh_base = v;
    endtask

    task automatic run_random(int n, int idle);
        ccl_in_t it;
        int r;
        send_idle_pct = idle;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(99);
            it.command = (r < 45) ? CMD_LOAD : (r < 90) ? CMD_STORE
                         : (r < 95) ? CMD_EMPTY : CMD_UNUSED;
            it.data_address = ($urandom_range(9) < 8) ? hot_address() : $urandom;
            pending_items.push_back(it);
        end
        wait_drained();
    endtask

    // stimulus sequence
    initial
    begin
        ccl_in_t it;
        start = 0;
        item = '0;
        base_we = 0;
        base_data = '0;
        rst_n = 0;
        sh_base = BASE_RESET;
        for (int i = 0; i < WAYS*SETS; i++)
        begin
            sh_valid[i] = 0;
            sh_dirty[i] = 0;
            sh_age[i] = '0;
            sh_tag[i] = '0;
        end
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed: extremes, all four command codes, fill then replace in one set
        it.command = CMD_LOAD;  it.data_address = 32'h0;          pending_items.push_back(it);
        it.command = CMD_STORE; it.data_address = 32'hFFFF_FFFF;  pending_items.push_back(it);
        it.command = CMD_EMPTY; it.data_address = 32'h1234_5678;  pending_items.push_back(it);
        it.command = CMD_UNUSED; it.data_address = 32'hFFFF_FFFF; pending_items.push_back(it);
        for (int k = 0; k < 6; k++)
        begin
            it.command = (k % 2) ? CMD_STORE : CMD_LOAD;
            it.data_address = {6'(k), 10'h000, 16'h0003};
            pending_items.push_back(it);
        end
        it.command = CMD_LOAD;  it.data_address = 32'h0000_0003;  pending_items.push_back(it);
        it.command = CMD_STORE; it.data_address = 32'h0000_0003;  pending_items.push_back(it);
        for (int k = 6; k < 10; k++)
        begin
            it.command = CMD_LOAD;
            it.data_address = {6'(k), 10'h000, 16'h0001};
            pending_items.push_back(it);
        end
        wait_drained();

        write_base(32'h0);
        run_random(220, 32);
        write_base(32'hFFFF_FFFF);
        it.command = CMD_STORE; it.data_address = 32'hFFFF_FFFF; pending_items.push_back(it);
        it.command = CMD_LOAD;  it.data_address = 32'h0;         pending_items.push_back(it);
        run_random(210, 53);
        write_base($urandom);
        run_random(220, 0);

        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #400000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
